// ----- sv/mcpf_pkg.sv -----
// Shared types and constants for the motor command packet framer.
package mcpf_pkg;

    // Configuration register indexes (byte address is 4 * index)
    localparam logic [2:0] REG_DRIVE_MODE      = 3'd0;
    localparam logic [2:0] REG_ERPM_FULL_SCALE = 3'd1;
    localparam logic [2:0] REG_MAX_CURRENT_MA  = 3'd2;
    localparam logic [2:0] REG_WHEEL0_ID       = 3'd3;
    localparam logic [2:0] REG_WHEEL1_ID       = 3'd4;
    localparam logic [2:0] REG_WHEEL2_ID       = 3'd5;
    localparam logic [2:0] REG_WHEEL3_ID       = 3'd6;

    // Control modes
    localparam logic [1:0] MODE_DUTY    = 2'd0;
    localparam logic [1:0] MODE_ERPM    = 2'd1;
    localparam logic [1:0] MODE_CURRENT = 2'd2;

    // Wheel select codes
    localparam logic [1:0] WHEEL_FL = 2'd0;
    localparam logic [1:0] WHEEL_FR = 2'd1;
    localparam logic [1:0] WHEEL_RL = 2'd2;
    localparam logic [1:0] WHEEL_RR = 2'd3;

    // Packet bytes and opcodes
    localparam logic [7:0] START_BYTE = 8'd2;
    localparam logic [7:0] END_BYTE   = 8'd3;
    localparam logic [7:0] OP_FORWARD = 8'd34;
    localparam logic [7:0] OP_DUTY    = 8'd5;
    localparam logic [7:0] OP_ERPM    = 8'd8;
    localparam logic [7:0] OP_CURRENT = 8'd6;
    localparam logic [7:0] LEN_FWD    = 8'd7;
    localparam logic [7:0] LEN_PLAIN  = 8'd5;

    localparam logic [15:0] CRC_POLY  = 16'h1021;
    localparam logic [17:0] DUTY_SCALE = 18'd100000;
    localparam logic signed [15:0] Q_ONE     = 16'sd16384;
    localparam logic signed [15:0] Q_NEG_ONE = -16'sd16384;

    // Byte positions within a packet with forward header
    localparam logic [3:0] POS_START  = 4'd0;
    localparam logic [3:0] POS_LEN    = 4'd1;
    localparam logic [3:0] POS_FWD_OP = 4'd2;
    localparam logic [3:0] POS_CAN_ID = 4'd3;
    localparam logic [3:0] POS_CMD_OP = 4'd4;
    localparam logic [3:0] POS_VAL3   = 4'd5;
    localparam logic [3:0] POS_VAL2   = 4'd6;
    localparam logic [3:0] POS_VAL1   = 4'd7;
    localparam logic [3:0] POS_VAL0   = 4'd8;
    localparam logic [3:0] POS_CRC_HI = 4'd9;
    localparam logic [3:0] POS_CRC_LO = 4'd10;
    localparam logic [3:0] POS_END    = 4'd11;

    localparam int FIFO_DEPTH_DEFAULT = 4;

    typedef struct packed {
        logic [1:0]  drive_mode;
        logic [16:0] erpm_full_scale;
        logic [17:0] max_current_ma;
        logic [8:0]  wheel0_id;
        logic [8:0]  wheel1_id;
        logic [8:0]  wheel2_id;
        logic [8:0]  wheel3_id;
    } cfg_t;

    // One classified command, ready for framing
    typedef struct packed {
        logic        fwd;
        logic [7:0]  can_id;
        logic [7:0]  opcode;
        logic [31:0] value;
    } desc_t;

endpackage

// ----- sv/mcpf_front.sv -----
// Front end: accepts wheel commands, clamps, scales and classifies them.
module mcpf_front (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [23:0]          s_tdata,   // [1:0] wheel_select, [17:2] speed_command
    input  mcpf_pkg::cfg_t       cfg,
    output logic                 push,
    input  logic                 full,
    output mcpf_pkg::desc_t      push_desc
);

    logic [1:0]         wheel;
    logic signed [15:0] spd;
    logic signed [15:0] clamped;
    logic               neg;
    logic [14:0]        mag;
    logic [17:0]        scale;
    logic [7:0]         opcode;
    logic [8:0]         id_sel;

    // stage A: clamped magnitude and scale
    logic        a_vld_reg;
    logic [14:0] a_mag_reg;
    logic        a_neg_reg;
    logic [17:0] a_scale_reg;
    logic [7:0]  a_op_reg;
    logic [8:0]  a_id_reg;

    // stage B: product
    logic        b_vld_reg;
    logic [31:0] b_prod_reg;
    logic        b_neg_reg;
    logic [7:0]  b_op_reg;
    logic [8:0]  b_id_reg;

    logic [32:0] prod_full;
    logic [17:0] q;
    logic        b_free;
    logic        a_move;
    logic        a_free;
    logic        accept;

    assign wheel = s_tdata[1:0];
    assign spd   = s_tdata[17:2];

    always_comb begin
        if (spd > mcpf_pkg::Q_ONE) begin
            clamped = mcpf_pkg::Q_ONE;
        end else if (spd < mcpf_pkg::Q_NEG_ONE) begin
            clamped = mcpf_pkg::Q_NEG_ONE;
        end else begin
            clamped = spd;
        end
        neg = clamped[15];
        mag = neg ? 15'(-clamped) : 15'(clamped);

        case (cfg.drive_mode)
            mcpf_pkg::MODE_ERPM: begin
                scale  = {1'b0, cfg.erpm_full_scale};
                opcode = mcpf_pkg::OP_ERPM;
            end
            mcpf_pkg::MODE_CURRENT: begin
                scale  = cfg.max_current_ma;
                opcode = mcpf_pkg::OP_CURRENT;
            end
            default: begin
                scale  = mcpf_pkg::DUTY_SCALE;
                opcode = mcpf_pkg::OP_DUTY;
            end
        endcase

        case (wheel)
            mcpf_pkg::WHEEL_FL: id_sel = cfg.wheel0_id;
            mcpf_pkg::WHEEL_FR: id_sel = cfg.wheel1_id;
            mcpf_pkg::WHEEL_RL: id_sel = cfg.wheel2_id;
            default:            id_sel = cfg.wheel3_id;
        endcase
    end

    assign push     = b_vld_reg && !full;
    assign b_free   = !b_vld_reg || push;
    assign a_move   = a_vld_reg && b_free;
    assign a_free   = !a_vld_reg || a_move;
    assign s_tready = a_free;
    assign accept   = s_tvalid && a_free;

    assign prod_full = 33'(a_mag_reg) * 33'(a_scale_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            a_vld_reg <= 1'b0;
            b_vld_reg <= 1'b0;
        end else begin
            if (a_free) begin
                a_vld_reg <= s_tvalid;
            end
            if (b_free) begin
                b_vld_reg <= a_vld_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            a_mag_reg   <= mag;
            a_neg_reg   <= neg;
            a_scale_reg <= scale;
            a_op_reg    <= opcode;
            a_id_reg    <= id_sel;
        end
        if (a_move) begin
            b_prod_reg <= prod_full[31:0];
            b_neg_reg  <= a_neg_reg;
            b_op_reg   <= a_op_reg;
            b_id_reg   <= a_id_reg;
        end
    end

    // divide by 2^14, truncating toward zero on the magnitude
    assign q = b_prod_reg[31:14];

    always_comb begin
        push_desc.fwd    = !b_id_reg[8];
        push_desc.can_id = b_id_reg[7:0];
        push_desc.opcode = b_op_reg;
        push_desc.value  = b_neg_reg ? (32'd0 - 32'(q)) : 32'(q);
    end

endmodule

// ----- sv/mcpf_fifo.sv -----
// Short descriptor queue between front and back ends.
module mcpf_fifo #(
    parameter int DEPTH = mcpf_pkg::FIFO_DEPTH_DEFAULT
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             push,
    input  mcpf_pkg::desc_t  push_desc,
    output logic             full,
    input  logic             pop,
    output logic             not_empty,
    output mcpf_pkg::desc_t  pop_desc
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [AW-1:0] LAST_PTR = AW'(DEPTH - 1);
    localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

    mcpf_pkg::desc_t mem [DEPTH];

    logic [AW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [AW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0] count_reg, count_next;

    assign full      = (count_reg == FULL_CNT);
    assign not_empty = (count_reg != '0);
    assign pop_desc  = mem[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop) begin
            count_next = count_reg + 1'b1;
        end else if (pop && !push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            mem[wr_ptr_reg] <= push_desc;
        end
    end

endmodule

// ----- sv/mcpf_back.sv -----
// Back end: serializes one descriptor into packet bytes with CRC-16 XMODEM.
module mcpf_back (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             not_empty,
    output logic             pop,
    input  mcpf_pkg::desc_t  pop_desc,
    output logic             m_tvalid,
    input  logic             m_tready,
    output logic [7:0]       m_tdata,   // [7:0] out_byte
    output logic             m_tlast
);

    function automatic logic [15:0] crc_byte(input logic [15:0] crc_in, input logic [7:0] b);
        logic [15:0] c;
        c = crc_in ^ {b, 8'h00};
        for (int k = 0; k < 8; k++) begin
            c = c[15] ? ({c[14:0], 1'b0} ^ mcpf_pkg::CRC_POLY) : {c[14:0], 1'b0};
        end
        return c;
    endfunction

    logic            busy_reg, busy_next;
    logic [3:0]      pos_reg, pos_next;
    mcpf_pkg::desc_t desc_reg;
    logic [15:0]     crc_reg, crc_next;
    logic [7:0]      tdata_reg;
    logic            tlast_reg;
    logic            tvalid_reg, tvalid_next;

    logic            emit;
    logic            last_pos;
    logic [7:0]      cur_byte;
    logic            is_payload;

    assign emit     = busy_reg && (!tvalid_reg || m_tready);
    assign last_pos = (pos_reg == mcpf_pkg::POS_END);
    // next descriptor is taken while the end byte goes out
    assign pop      = not_empty && (!busy_reg || (emit && last_pos));

    always_comb begin
        case (pos_reg)
            mcpf_pkg::POS_START:  cur_byte = mcpf_pkg::START_BYTE;
            mcpf_pkg::POS_LEN:    cur_byte = desc_reg.fwd ? mcpf_pkg::LEN_FWD
                                                          : mcpf_pkg::LEN_PLAIN;
            mcpf_pkg::POS_FWD_OP: cur_byte = mcpf_pkg::OP_FORWARD;
            mcpf_pkg::POS_CAN_ID: cur_byte = desc_reg.can_id;
            mcpf_pkg::POS_CMD_OP: cur_byte = desc_reg.opcode;
            mcpf_pkg::POS_VAL3:   cur_byte = desc_reg.value[31:24];
            mcpf_pkg::POS_VAL2:   cur_byte = desc_reg.value[23:16];
            mcpf_pkg::POS_VAL1:   cur_byte = desc_reg.value[15:8];
            mcpf_pkg::POS_VAL0:   cur_byte = desc_reg.value[7:0];
            mcpf_pkg::POS_CRC_HI: cur_byte = crc_reg[15:8];
            mcpf_pkg::POS_CRC_LO: cur_byte = crc_reg[7:0];
            default:              cur_byte = mcpf_pkg::END_BYTE;
        endcase
        is_payload = pos_reg inside {[mcpf_pkg::POS_FWD_OP:mcpf_pkg::POS_VAL0]};
    end

    always_comb begin
        busy_next   = busy_reg;
        pos_next    = pos_reg;
        crc_next    = crc_reg;
        tvalid_next = (tvalid_reg && !m_tready) ? 1'b1 : 1'b0;

        if (emit) begin
            tvalid_next = 1'b1;
            if (is_payload) begin
                crc_next = crc_byte(crc_reg, cur_byte);
            end
            // without forward header, skip from length straight to the opcode
            if (pos_reg == mcpf_pkg::POS_LEN && !desc_reg.fwd) begin
                pos_next = mcpf_pkg::POS_CMD_OP;
            end else begin
                pos_next = pos_reg + 1'b1;
            end
            if (last_pos) begin
                busy_next = 1'b0;
            end
        end
        if (pop) begin
            busy_next = 1'b1;
            pos_next  = mcpf_pkg::POS_START;
            crc_next  = '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg   <= 1'b0;
            tvalid_reg <= 1'b0;
            pos_reg    <= mcpf_pkg::POS_START;
        end else begin
            busy_reg   <= busy_next;
            tvalid_reg <= tvalid_next;
            pos_reg    <= pos_next;
        end
    end

    always_ff @(posedge aclk) begin
        crc_reg <= crc_next;
        if (pop) begin
            desc_reg <= pop_desc;
        end
        if (emit) begin
            tdata_reg <= cur_byte;
            tlast_reg <= last_pos;
        end
    end

    assign m_tvalid = tvalid_reg;
    assign m_tdata  = tdata_reg;
    assign m_tlast  = tlast_reg;

endmodule

// ----- sv/motor_command_packet_framer_core.sv -----
// Top level of the motor command packet framer: config registers and the three parts.
// Each accepted word is one wheel command: a wheel number and a signed Q2.14 speed, which
// is clamped to +/-1.0, scaled by the control mode (duty x100000, eRPM x the eRPM
// full-scale register, current x max_current_ma, truncated toward zero) and framed as a
// serial packet: start byte 2,
// payload length, an optional CAN-forward header (34 and the wheel's CAN id, present when
// that id is not negative), opcode, 32-bit value big-endian, CRC-16 XMODEM of the payload
// high byte first, and end byte 3 flagged by m_tlast. A packet is 12 bytes with the
// forward header and 10 without; the output moves one byte word per cycle unless m_tready
// stalls it. Packets follow one another with no idle cycle when the next command is
// already queued. The input side takes one word per cycle through a two-stage scale
// pipeline into a FIFO_DEPTH-entry command queue and stalls only when that queue is full;
// when the serializer is free, the first byte of a packet passes stage A, stage B, the
// queue and the serializer's descriptor and output registers once its command is accepted.
// Registers sit on the APB port at byte address 4*index and should only be written while
// no packet is pending; they are read back with CAN ids sign-extended.
module motor_command_packet_framer_core #(
    parameter int FIFO_DEPTH = mcpf_pkg::FIFO_DEPTH_DEFAULT
) (
    input  logic        aclk,
    input  logic        aresetn,
    // command input
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [23:0] s_tdata,   // [1:0] wheel_select, [17:2] speed_command, rest zero
    // packet byte output
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata,   // [7:0] out_byte
    output logic        m_tlast,   // last_byte
    // configuration
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    logic [1:0]  drive_mode_reg;
    logic [16:0] erpm_scale_reg;
    logic [17:0] max_current_reg;
    logic [8:0]  fl_id_reg;
    logic [8:0]  fr_id_reg;
    logic [8:0]  rl_id_reg;
    logic [8:0]  rr_id_reg;

    logic [2:0]  reg_idx;
    logic        wr_en;

    mcpf_pkg::cfg_t  cfg;
    mcpf_pkg::desc_t push_desc;
    mcpf_pkg::desc_t pop_desc;
    logic            push;
    logic            full;
    logic            pop;
    logic            not_empty;

    assign pready  = 1'b1;
    assign reg_idx = paddr[4:2];
    assign wr_en   = psel && penable && pwrite;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            drive_mode_reg   <= mcpf_pkg::MODE_DUTY;
            erpm_scale_reg   <= 17'd15000;
            max_current_reg  <= 18'd30000;
            fl_id_reg        <= 9'd1;
            fr_id_reg        <= 9'd2;
            rl_id_reg        <= 9'd3;
            rr_id_reg        <= 9'd4;
        end else if (wr_en) begin
            case (reg_idx)
                mcpf_pkg::REG_DRIVE_MODE:      drive_mode_reg  <= pwdata[1:0];
                mcpf_pkg::REG_ERPM_FULL_SCALE: erpm_scale_reg  <= pwdata[16:0];
                mcpf_pkg::REG_MAX_CURRENT_MA:  max_current_reg <= pwdata[17:0];
                mcpf_pkg::REG_WHEEL0_ID:       fl_id_reg       <= pwdata[8:0];
                mcpf_pkg::REG_WHEEL1_ID:       fr_id_reg       <= pwdata[8:0];
                mcpf_pkg::REG_WHEEL2_ID:       rl_id_reg       <= pwdata[8:0];
                mcpf_pkg::REG_WHEEL3_ID:       rr_id_reg       <= pwdata[8:0];
                default: ;
            endcase
        end
    end

    // readback; CAN ids sign-extended
    always_comb begin
        case (reg_idx)
            mcpf_pkg::REG_DRIVE_MODE:      prdata = 32'(drive_mode_reg);
            mcpf_pkg::REG_ERPM_FULL_SCALE: prdata = 32'(erpm_scale_reg);
            mcpf_pkg::REG_MAX_CURRENT_MA:  prdata = 32'(max_current_reg);
            mcpf_pkg::REG_WHEEL0_ID:       prdata = {{23{fl_id_reg[8]}}, fl_id_reg};
            mcpf_pkg::REG_WHEEL1_ID:       prdata = {{23{fr_id_reg[8]}}, fr_id_reg};
            mcpf_pkg::REG_WHEEL2_ID:       prdata = {{23{rl_id_reg[8]}}, rl_id_reg};
            mcpf_pkg::REG_WHEEL3_ID:       prdata = {{23{rr_id_reg[8]}}, rr_id_reg};
            default:                       prdata = 32'd0;
        endcase
    end

    always_comb begin
        cfg.drive_mode      = drive_mode_reg;
        cfg.erpm_full_scale = erpm_scale_reg;
        cfg.max_current_ma  = max_current_reg;
        cfg.wheel0_id       = fl_id_reg;
        cfg.wheel1_id       = fr_id_reg;
        cfg.wheel2_id       = rl_id_reg;
        cfg.wheel3_id       = rr_id_reg;
    end

    // clamp, scale and classify
    mcpf_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .cfg       (cfg),
        .push      (push),
        .full      (full),
        .push_desc (push_desc)
    );

    // command queue decoupling front from serializer
    mcpf_fifo #(
        .DEPTH (FIFO_DEPTH)
    ) u_fifo (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (push),
        .push_desc (push_desc),
        .full      (full),
        .pop       (pop),
        .not_empty (not_empty),
        .pop_desc  (pop_desc)
    );

    // byte serializer with running CRC
    mcpf_back u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .not_empty (not_empty),
        .pop       (pop),
        .pop_desc  (pop_desc),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast)
    );

endmodule
